@@ hw/rtl/u8d_pkg.sv @@
`default_nettype none

package u8d_pkg;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw    = $clog2(QDepth);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        is_error;
		logic        last_of_run;
		logic        text_done;
	} out_word_t;

	// One queued job: err_cnt error words, then one closing word.
	typedef struct packed {
		logic [1:0]  err_cnt;
		logic [20:0] tail_cp;
		logic        tail_err;
		logic        eot;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/u8d_front.sv @@
`default_nettype none

module u8d_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire u8d_pkg::in_word_t word,
	output logic                  job_valid,
	output u8d_pkg::job_t         job
);
	import u8d_pkg::*;

	logic [1:0]  rem_q;
	logic [1:0]  taken_q;
	logic [20:0] acc_q;

	logic [1:0]  rem_d;
	logic [1:0]  taken_d;
	logic [20:0] acc_d;

	logic [7:0]  b;
	logic        eot;
	logic        is_cont;
	logic        ascii;
	logic        l2;
	logic        l3;
	logic        l4;
	logic        seq_lead;
	logic        lead_res;
	logic [20:0] lead_cp;
	logic [1:0]  lead_rem;
	logic [20:0] lead_acc;
	logic [20:0] cont_acc;
	logic [1:0]  cont_taken;
	logic [1:0]  cont_rem;

	always_comb begin
		b        = word.data_byte;
		eot      = word.end_of_text;
		is_cont  = (b[7:6] == 2'b10);
		ascii    = ~b[7];
		l2       = (b[7:5] == 3'b110);
		l3       = (b[7:4] == 4'b1110);
		l4       = (b[7:3] == 5'b11110);
		seq_lead = l2 | l3 | l4;
		lead_res = ~seq_lead | eot;
		lead_cp  = ascii ? {13'd0, b} : 21'd0;
		if (l2) begin
			lead_rem = 2'd1;
			lead_acc = {16'd0, b[4:0]};
		end else if (l3) begin
			lead_rem = 2'd2;
			lead_acc = {17'd0, b[3:0]};
		end else begin
			lead_rem = 2'd3;
			lead_acc = {18'd0, b[2:0]};
		end
		cont_acc   = {acc_q[14:0], b[5:0]};
		cont_taken = taken_q + 2'd1;
		cont_rem   = rem_q - 2'd1;

		rem_d         = rem_q;
		taken_d       = taken_q;
		acc_d         = acc_q;
		job_valid     = 1'b0;
		job.err_cnt   = 2'd0;
		job.tail_cp   = 21'd0;
		job.tail_err  = 1'b1;
		job.eot       = eot;

		if (rem_q != 2'd0 && is_cont) begin
			if (cont_rem == 2'd0) begin
				job_valid    = 1'b1;
				job.tail_cp  = cont_acc;
				job.tail_err = 1'b0;
				rem_d        = 2'd0;
				taken_d      = 2'd0;
				acc_d        = 21'd0;
			end else if (eot) begin
				job_valid   = 1'b1;
				job.err_cnt = cont_taken - 2'd1;
				rem_d       = 2'd0;
				taken_d     = 2'd0;
				acc_d       = 21'd0;
			end else begin
				rem_d   = cont_rem;
				taken_d = cont_taken;
				acc_d   = cont_acc;
			end
		end else begin
			if (rem_q != 2'd0) begin
				job_valid   = 1'b1;
				job.err_cnt = lead_res ? taken_q : taken_q - 2'd1;
			end else begin
				job_valid = lead_res;
			end
			if (lead_res) begin
				job.tail_cp  = lead_cp;
				job.tail_err = ~ascii;
			end
			if (seq_lead && !eot) begin
				rem_d   = lead_rem;
				taken_d = 2'd1;
				acc_d   = lead_acc;
			end else begin
				rem_d   = 2'd0;
				taken_d = 2'd0;
				acc_d   = 21'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= 2'd0;
			taken_q <= 2'd0;
			acc_q   <= 21'd0;
		end else if (take) begin
			rem_q   <= rem_d;
			taken_q <= taken_d;
			acc_q   <= acc_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/u8d_queue.sv @@
`default_nettype none

module u8d_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire u8d_pkg::job_t push_job,
	input  wire logic          pop,
	output u8d_pkg::job_t      head,
	output u8d_pkg::q_stat_t   stat
);
	import u8d_pkg::*;

	job_t           mem_q [QDepth];
	logic [QAw-1:0] wptr_q;
	logic [QAw-1:0] rptr_q;
	logic [QAw:0]   cnt_q;

	always_comb begin
		head       = mem_q[rptr_q];
		stat.full  = (cnt_q == (QAw+1)'(QDepth));
		stat.empty = (cnt_q == '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/u8d_back.sv @@
`default_nettype none

module u8d_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire u8d_pkg::job_t    head,
	input  wire logic             head_valid,
	output logic                  pop,
	output logic                  cp_valid,
	input  wire logic             cp_ready,
	output u8d_pkg::out_word_t    cp_word
);
	import u8d_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_q;

	logic       load;
	logic       is_tail;
	out_word_t  nxt;

	always_comb begin
		load    = head_valid && (!out_valid_q || cp_ready);
		is_tail = (idx_q == head.err_cnt);
		pop     = load && is_tail;
		if (is_tail) begin
			nxt.code_point  = head.tail_cp;
			nxt.is_error    = head.tail_err;
			nxt.last_of_run = 1'b1;
			nxt.text_done   = head.eot;
		end else begin
			nxt.code_point  = 21'd0;
			nxt.is_error    = 1'b1;
			nxt.last_of_run = 1'b0;
			nxt.text_done   = 1'b0;
		end
		cp_valid = out_valid_q;
		cp_word  = out_q;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_tail ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (cp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/utf8_stream_decoder.sv @@
// A byte that yields results writes its job into the queue; the back end then loads its
// first word into the output register. Throughput: one byte per cycle unless the queue
// is full, and one word per cycle out while cp_ready holds; a four-entry queue sits between.
// Reset: arst_n clears the pending sequence, the queue and the output register at once.
`default_nettype none

module utf8_stream_decoder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               src_valid,
	output logic                    src_ready,
	input  wire u8d_pkg::in_word_t  src_word,
	output logic                    cp_valid,
	input  wire logic               cp_ready,
	output u8d_pkg::out_word_t      cp_word
);
	import u8d_pkg::*;

	logic    take;
	logic    job_valid;
	job_t    job;
	logic    push;
	logic    pop;
	job_t    head;
	q_stat_t stat;

	assign src_ready = !stat.full;
	assign take      = src_valid && src_ready;
	assign push      = take && job_valid;

	u8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.word      (src_word),
		.job_valid (job_valid),
		.job       (job)
	);

	u8d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	u8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!stat.empty),
		.pop        (pop),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.cp_word    (cp_word)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && cp_word.is_error |-> cp_word.code_point == 21'd0)
		else $error("error word carries a nonzero code point");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && cp_word.text_done |-> cp_word.last_of_run)
		else $error("end of text flagged on a word that does not close its byte");

	a_q_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue reports full and empty together");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("job pushed into a full queue");

endmodule

`default_nettype wire
